[src/pid_clamped_antiwindup_unit_assert.svh]
// Assertion macros shared by the controller modules.
`ifndef PID_CLAMPED_ANTIWINDUP_UNIT_ASSERT_SVH
`define PID_CLAMPED_ANTIWINDUP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define PCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/pca_pkg.sv]
// Shared constants, register codes and width helpers of the PID controller.
package pca_pkg;

    localparam int ERR_W      = 32;
    localparam int LIM_W      = 31;
    localparam int DE_W       = ERR_W + 1;
    localparam int PROD_W     = 2 * ERR_W;
    localparam int DPROD_W    = ERR_W + DE_W;
    localparam int DCLIP_W    = LIM_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_STEP_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_RATE_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT  = 2'd3;

    localparam logic [LIM_W-1:0] LIM_RESET = 31'd6553600;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Width of a gain times error product after the fraction shift.
    function automatic int ps_w(input int frac);
        return PROD_W - frac;
    endfunction

    // Width of the proportional plus clipped derivative sum.
    function automatic int pd_w(input int frac);
        return imax(ps_w(frac), DCLIP_W) + 1;
    endfunction

endpackage

[src/pca_in_if.sv]
// Input channel carrying one error sample per item.
interface pca_in_if import pca_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_in;

    modport source (output valid, output error_in, input ready);
    modport sink   (input valid, input error_in, output ready);
endinterface

[src/pca_out_if.sv]
// Output channel carrying one drive value and its clip flags per item.
interface pca_out_if import pca_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] drive_out;
    logic                    out_clipped;
    logic                    deriv_clipped;

    modport source (output valid, output drive_out, output out_clipped,
                    output deriv_clipped, input ready);
    modport sink   (input valid, input drive_out, input out_clipped,
                    input deriv_clipped, output ready);
endinterface

[src/pca_mult.sv]
// Product stage: the three gain multiplications, registered.
module pca_mult import pca_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [ERR_W-1:0]   i_e,
    input  logic signed [DE_W-1:0]    i_de,
    input  logic signed [ERR_W-1:0]   i_p_gain,
    input  logic signed [ERR_W-1:0]   i_i_gain,
    input  logic signed [ERR_W-1:0]   i_d_gain,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [PROD_W-1:0]  o_p_prod,
    output logic signed [PROD_W-1:0]  o_i_prod,
    output logic signed [DPROD_W-1:0] o_d_prod
);

    logic                      r_valid;
    logic signed [PROD_W-1:0]  r_p_prod;
    logic signed [PROD_W-1:0]  r_i_prod;
    logic signed [DPROD_W-1:0] r_d_prod;
    logic signed [PROD_W-1:0]  n_p_prod;
    logic signed [PROD_W-1:0]  n_i_prod;
    logic signed [DPROD_W-1:0] n_d_prod;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_p_prod = PROD_W'(i_p_gain) * PROD_W'(i_e);
        n_i_prod = PROD_W'(i_i_gain) * PROD_W'(i_e);
        n_d_prod = DPROD_W'(i_d_gain) * DPROD_W'(i_de);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_p_prod <= n_p_prod;
            r_i_prod <= n_i_prod;
            r_d_prod <= n_d_prod;
        end
    end

    assign o_valid  = r_valid;
    assign o_p_prod = r_p_prod;
    assign o_i_prod = r_i_prod;
    assign o_d_prod = r_d_prod;

endmodule

[src/pca_prep.sv]
// Scaling stage: fraction shift, derivative clip, partial sums and rewrite values.
module pca_prep import pca_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [PROD_W-1:0]          i_p_prod,
    input  logic signed [PROD_W-1:0]          i_i_prod,
    input  logic signed [DPROD_W-1:0]         i_d_prod,
    input  logic        [LIM_W-1:0]           i_lim,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pd_w(FRAC_BITS)-1:0] o_pd,
    output logic signed [ps_w(FRAC_BITS)-1:0] o_i_inc,
    output logic signed [DATA_WIDTH-1:0]      o_rw_hi,
    output logic signed [DATA_WIDTH-1:0]      o_rw_lo,
    output logic                              o_dclip
);

    localparam int PS  = ps_w(FRAC_BITS);
    localparam int PDW = pd_w(FRAC_BITS);
    localparam int DS  = DPROD_W - FRAC_BITS;
    localparam int LW  = imax(PS, DATA_WIDTH) + 2;
    localparam logic signed [LW-1:0] SAT_HI =
        {{(LW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [LW-1:0] SAT_LO = ~SAT_HI;

    logic                         r_valid;
    logic signed [PDW-1:0]        r_pd;
    logic signed [PS-1:0]         r_i_inc;
    logic signed [DATA_WIDTH-1:0] r_rw_hi;
    logic signed [DATA_WIDTH-1:0] r_rw_lo;
    logic                         r_dclip;

    logic signed [PS-1:0]         w_p;
    logic signed [DS-1:0]         w_d;
    logic signed [DS-1:0]         w_lim_d;
    logic signed [DCLIP_W-1:0]    w_dc;
    logic signed [LW-1:0]         w_lim_l;
    logic signed [LW-1:0]         w_hi_raw;
    logic signed [LW-1:0]         w_lo_raw;
    logic signed [PDW-1:0]        n_pd;
    logic signed [DATA_WIDTH-1:0] n_rw_hi;
    logic signed [DATA_WIDTH-1:0] n_rw_lo;
    logic                         n_dclip;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_p     = i_p_prod[PROD_W-1:FRAC_BITS];
        w_d     = i_d_prod[DPROD_W-1:FRAC_BITS];
        w_lim_d = signed'(DS'(i_lim));
        n_dclip = 1'b1;
        if (w_d > w_lim_d) begin
            w_dc = signed'(DCLIP_W'(i_lim));
        end else if (w_d < -w_lim_d) begin
            w_dc = -signed'(DCLIP_W'(i_lim));
        end else begin
            w_dc    = DCLIP_W'(w_d);
            n_dclip = 1'b0;
        end
        n_pd = PDW'(w_p) + PDW'(w_dc);

        w_lim_l  = signed'(LW'(i_lim));
        w_hi_raw = w_lim_l - LW'(w_p);
        w_lo_raw = -w_lim_l - LW'(w_p);
        if (w_hi_raw > SAT_HI) begin
            n_rw_hi = SAT_HI[DATA_WIDTH-1:0];
        end else if (w_hi_raw < SAT_LO) begin
            n_rw_hi = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            n_rw_hi = w_hi_raw[DATA_WIDTH-1:0];
        end
        if (w_lo_raw > SAT_HI) begin
            n_rw_lo = SAT_HI[DATA_WIDTH-1:0];
        end else if (w_lo_raw < SAT_LO) begin
            n_rw_lo = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            n_rw_lo = w_lo_raw[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pd    <= n_pd;
            r_i_inc <= i_i_prod[PROD_W-1:FRAC_BITS];
            r_rw_hi <= n_rw_hi;
            r_rw_lo <= n_rw_lo;
            r_dclip <= n_dclip;
        end
    end

    assign o_valid = r_valid;
    assign o_pd    = r_pd;
    assign o_i_inc = r_i_inc;
    assign o_rw_hi = r_rw_hi;
    assign o_rw_lo = r_rw_lo;
    assign o_dclip = r_dclip;

endmodule

[src/pca_integ.sv]
// Result stage: integral update, output clip with back-calculation, result register.
`include "pid_clamped_antiwindup_unit_assert.svh"

module pca_integ import pca_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [pd_w(FRAC_BITS)-1:0] i_pd,
    input  logic signed [ps_w(FRAC_BITS)-1:0] i_i_inc,
    input  logic signed [DATA_WIDTH-1:0]      i_rw_hi,
    input  logic signed [DATA_WIDTH-1:0]      i_rw_lo,
    input  logic                              i_dclip,
    input  logic        [LIM_W-1:0]           i_lim,
    input  logic signed [ERR_W-1:0]           i_i_gain,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ERR_W-1:0]           o_drive,
    output logic                              o_oclip,
    output logic                              o_dclip
);

    localparam int PS  = ps_w(FRAC_BITS);
    localparam int PDW = pd_w(FRAC_BITS);
    localparam int AW  = imax(PS, DATA_WIDTH) + 1;
    localparam int SW  = imax(PDW, DATA_WIDTH) + 1;
    localparam logic signed [AW-1:0] SAT_HI =
        {{(AW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_integ;
    logic signed [ERR_W-1:0]      r_drive;
    logic                         r_oclip;
    logic                         r_dclip;

    logic                         w_load;
    logic signed [AW-1:0]         w_acc;
    logic signed [DATA_WIDTH-1:0] w_i_acc;
    logic signed [SW-1:0]         w_sum;
    logic signed [SW-1:0]         w_lim_s;
    logic signed [DATA_WIDTH-1:0] n_integ;
    logic signed [ERR_W-1:0]      n_drive;
    logic                         n_oclip;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        w_acc = AW'(r_integ) + AW'(i_i_inc);
        if (i_i_gain == '0) begin
            w_i_acc = '0;
        end else if (w_acc > SAT_HI) begin
            w_i_acc = SAT_HI[DATA_WIDTH-1:0];
        end else if (w_acc < SAT_LO) begin
            w_i_acc = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            w_i_acc = w_acc[DATA_WIDTH-1:0];
        end

        w_sum   = SW'(i_pd) + SW'(w_i_acc);
        w_lim_s = signed'(SW'(i_lim));
        if (w_sum > w_lim_s) begin
            n_drive = signed'(ERR_W'(i_lim));
            n_integ = i_rw_hi;
            n_oclip = 1'b1;
        end else if (w_sum < -w_lim_s) begin
            n_drive = -signed'(ERR_W'(i_lim));
            n_integ = i_rw_lo;
            n_oclip = 1'b1;
        end else begin
            n_drive = w_sum[ERR_W-1:0];
            n_integ = w_i_acc;
            n_oclip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_integ <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drive <= n_drive;
            r_oclip <= n_oclip;
            r_dclip <= i_dclip;
        end
    end

    assign o_valid = r_valid;
    assign o_drive = r_drive;
    assign o_oclip = r_oclip;
    assign o_dclip = r_dclip;

    `PCA_ASSERT_NEXT(a_integ_holds_without_item, !w_load, $stable(r_integ))
    `PCA_ASSERT_NEXT(a_zero_gain_clears_integ, w_load && i_i_gain == '0 && !n_oclip, r_integ == '0)

endmodule

[src/pid_clamped_antiwindup_unit.sv]
// Clipped PID controller with back-calculation anti-windup, Q16.16 fixed point.
// The block takes one error sample per cycle while no stage is held by a waiting
// result, and presents one drive value per sample, through a four-register
// pipeline: input and difference register, the three gain multipliers, the
// fraction shift with derivative clip, and the result register in which the
// integral is updated and the output clip closes. Each stage moves when the one
// after it is empty or moving, so while a result waits at the output the block
// takes three more items and then holds its input. Gains and the limit are
// meant to be written while no item is in flight.
`include "pid_clamped_antiwindup_unit_assert.svh"

module pid_clamped_antiwindup_unit import pca_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pca_in_if.sink                i_in,
    pca_out_if.source             o_out
);

    localparam int PS  = ps_w(FRAC_BITS);
    localparam int PDW = pd_w(FRAC_BITS);

    logic signed [ERR_W-1:0] r_p_gain;
    logic signed [ERR_W-1:0] r_i_gain;
    logic signed [ERR_W-1:0] r_d_gain;
    logic        [LIM_W-1:0] r_lim;

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_e;
    logic signed [DE_W-1:0]  r_de;
    logic signed [ERR_W-1:0] r_last_err;
    logic                    w_ready;
    logic                    w_accept;

    logic                      w_mult_ready;
    logic                      w_mult_valid;
    logic signed [PROD_W-1:0]  w_p_prod;
    logic signed [PROD_W-1:0]  w_i_prod;
    logic signed [DPROD_W-1:0] w_d_prod;

    logic                         w_prep_ready;
    logic                         w_prep_valid;
    logic signed [PDW-1:0]        w_pd;
    logic signed [PS-1:0]         w_i_inc;
    logic signed [DATA_WIDTH-1:0] w_rw_hi;
    logic signed [DATA_WIDTH-1:0] w_rw_lo;
    logic                         w_dclip;

    logic                    w_integ_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain <= '0;
            r_i_gain <= '0;
            r_d_gain <= '0;
            r_lim    <= LIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_P_GAIN: begin
                    r_p_gain <= signed'(i_cfg_data[ERR_W-1:0]);
                end
                REG_I_STEP_GAIN: begin
                    r_i_gain <= signed'(i_cfg_data[ERR_W-1:0]);
                end
                REG_D_RATE_GAIN: begin
                    r_d_gain <= signed'(i_cfg_data[ERR_W-1:0]);
                end
                REG_CLIP_LIMIT: begin
                    r_lim <= i_cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ready    = !r_valid || w_mult_ready;
    assign w_accept   = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (w_ready) begin
                r_valid <= i_in.valid;
            end
            if (w_accept) begin
                r_last_err <= i_in.error_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e  <= i_in.error_in;
            r_de <= DE_W'(i_in.error_in) - DE_W'(r_last_err);
        end
    end

    pca_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_valid),
        .o_ready  (w_mult_ready),
        .i_e      (r_e),
        .i_de     (r_de),
        .i_p_gain (r_p_gain),
        .i_i_gain (r_i_gain),
        .i_d_gain (r_d_gain),
        .o_valid  (w_mult_valid),
        .i_ready  (w_prep_ready),
        .o_p_prod (w_p_prod),
        .o_i_prod (w_i_prod),
        .o_d_prod (w_d_prod)
    );

    pca_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mult_valid),
        .o_ready  (w_prep_ready),
        .i_p_prod (w_p_prod),
        .i_i_prod (w_i_prod),
        .i_d_prod (w_d_prod),
        .i_lim    (r_lim),
        .o_valid  (w_prep_valid),
        .i_ready  (w_integ_ready),
        .o_pd     (w_pd),
        .o_i_inc  (w_i_inc),
        .o_rw_hi  (w_rw_hi),
        .o_rw_lo  (w_rw_lo),
        .o_dclip  (w_dclip)
    );

    pca_integ #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_integ (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_prep_valid),
        .o_ready  (w_integ_ready),
        .i_pd     (w_pd),
        .i_i_inc  (w_i_inc),
        .i_rw_hi  (w_rw_hi),
        .i_rw_lo  (w_rw_lo),
        .i_dclip  (w_dclip),
        .i_lim    (r_lim),
        .i_i_gain (r_i_gain),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_drive  (o_out.drive_out),
        .o_oclip  (o_out.out_clipped),
        .o_dclip  (o_out.deriv_clipped)
    );

    `PCA_ASSERT_IMPL(a_empty_output_takes_item, !o_out.valid, i_in.ready)

endmodule

[verif/tb.sv]
// Self-checking testbench for the clipped PID controller with anti-windup.
module tb import pca_pkg::*;;

    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [ERR_W-1:0] drive;
        logic                    oclip;
        logic                    dclip;
    } t_drive_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pca_in_if  in_ch();
    pca_out_if out_ch();

    pid_clamped_antiwindup_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_drive_result pending_drives[$];
    int            mismatches = 0;
    int            quiet_cycles = 0;
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;

    longint ctl_kp;
    longint ctl_ki;
    longint ctl_kd;
    longint ctl_limit;
    longint ctl_integral;
    longint ctl_last_error;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint sat_word(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic t_drive_result predict_drive(input logic signed [ERR_W-1:0] e);
        longint        ev;
        longint        p;
        longint        d;
        longint        sum;
        longint        drv;
        t_drive_result r;
        ev = e;
        r.oclip = 1'b0;
        r.dclip = 1'b0;
        p = (ctl_kp * ev) >>> FRAC_BITS_DEF;
        if (ctl_ki != 0) begin
            ctl_integral = sat_word(ctl_integral + ((ctl_ki * ev) >>> FRAC_BITS_DEF));
        end else begin
            ctl_integral = 0;
        end
        d = (ctl_kd * (ev - ctl_last_error)) >>> FRAC_BITS_DEF;
        ctl_last_error = ev;
        if (d > ctl_limit) begin
            d = ctl_limit;
            r.dclip = 1'b1;
        end else if (d < -ctl_limit) begin
            d = -ctl_limit;
            r.dclip = 1'b1;
        end
        sum = p + d + ctl_integral;
        drv = sum;
        if (sum > ctl_limit) begin
            ctl_integral = sat_word(ctl_limit - p);
            drv = ctl_limit;
            r.oclip = 1'b1;
        end else if (sum < -ctl_limit) begin
            ctl_integral = sat_word(-ctl_limit - p);
            drv = -ctl_limit;
            r.oclip = 1'b1;
        end
        r.drive = drv[ERR_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_P_GAIN:      ctl_kp = longint'(signed'(data));
            REG_I_STEP_GAIN: ctl_ki = longint'(signed'(data));
            REG_D_RATE_GAIN: ctl_kd = longint'(signed'(data));
            REG_CLIP_LIMIT:  ctl_limit = longint'(data[LIM_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_controller(input logic [31:0] kp, input logic [31:0] ki,
                                  input logic [31:0] kd, input logic [31:0] lim);
        write_reg(REG_P_GAIN, kp);
        write_reg(REG_I_STEP_GAIN, ki);
        write_reg(REG_D_RATE_GAIN, kd);
        write_reg(REG_CLIP_LIMIT, lim);
    endtask

    task automatic send_error(input logic signed [ERR_W-1:0] e);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.error_in <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_drives.push_back(predict_drive(e));
    endtask

    task automatic finish_burst();
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return $urandom();
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 6))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return {1'b0, LIM_RESET};
            3: return $urandom();
            default: return $urandom_range(1, 32'h0040_0000);
        endcase
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error();
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    task automatic test_reset_state();
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh8000_0000);
        send_error(32'sh0000_0000);
        finish_burst();
    endtask

    task automatic test_proportional();
        set_controller(32'h0001_0000, 32'h0, 32'h0, {1'b0, LIM_RESET});
        send_error(32'sd50 <<< 16);
        send_error(32'sd100 <<< 16);
        send_error((32'sd100 <<< 16) + 1);
        send_error(-(32'sd100 <<< 16));
        send_error(-(32'sd100 <<< 16) - 1);
        finish_burst();
        write_reg(REG_P_GAIN, 32'h0000_8000);
        send_error(-32'sd1);
        finish_burst();
    endtask

    task automatic test_integral();
        set_controller(32'h0, 32'h0001_0000, 32'h0, {1'b0, LIM_RESET});
        send_error(32'sd60 <<< 16);
        send_error(32'sd60 <<< 16);
        send_error(-(32'sd10 <<< 16));
        finish_burst();
        write_reg(REG_I_STEP_GAIN, 32'h0);
        send_error(32'sd5 <<< 16);
        finish_burst();
        write_reg(REG_I_STEP_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_CLIP_LIMIT, 32'h7FFF_FFFF);
        send_error(32'sh7FFF_FFFF);
        send_error(32'sh8000_0000);
        finish_burst();
    endtask

    task automatic test_derivative();
        set_controller(32'h0, 32'h0, 32'h0001_0000, {1'b0, LIM_RESET});
        send_error(32'sd0);
        send_error(32'sd50 <<< 16);
        send_error(32'sd50 <<< 16);
        send_error(-(32'sd60 <<< 16));
        finish_burst();
        write_reg(REG_P_GAIN, 32'h0001_0000);
        send_error(-(32'sd60 <<< 16));
        finish_burst();
    endtask

    task automatic test_limit_edges();
        set_controller(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_error(32'sd1);
        send_error(32'sd0);
        finish_burst();
        write_reg(REG_CLIP_LIMIT, 32'h8000_0064);
        send_error(32'sd100);
        send_error(32'sd101);
        finish_burst();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 10; phase++) begin
            set_controller(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            idle_on = (phase < 8);
            if (phase == 3) hold_req = 1'b1;
            for (int n = 0; n < 70; n++) begin
                send_error(pick_error());
            end
            finish_burst();
        end
    endtask

    initial begin : result_ready
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_drives.size() == 0) begin
                report("unexpected item", 32'h0, out_ch.drive_out);
            end else begin
                want = pending_drives.pop_front();
                if (out_ch.drive_out !== want.drive)
                    report("drive_out", want.drive, out_ch.drive_out);
                if (out_ch.out_clipped !== want.oclip)
                    report("out_clipped", 32'(want.oclip), 32'(out_ch.out_clipped));
                if (out_ch.deriv_clipped !== want.dclip)
                    report("deriv_clipped", 32'(want.dclip), 32'(out_ch.deriv_clipped));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_P_GAIN;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.error_in <= '0;
        ctl_kp         = 0;
        ctl_ki         = 0;
        ctl_kd         = 0;
        ctl_limit      = longint'(LIM_RESET);
        ctl_integral   = 0;
        ctl_last_error = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_proportional();
        test_integral();
        test_derivative();
        test_limit_edges();
        test_random_phases();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
